// ===== hdl/mvkd_pkg.sv =====
// Package for the MPEG video keyframe detector.
// Holds the stream kind, scan phase, decision cause, item and result types and the byte constants.
// No dependencies.
package mvkd_pkg;

    localparam logic [7:0] BYTE_ZERO     = 8'h00;
    localparam logic [7:0] BYTE_ONE      = 8'h01;
    localparam logic [7:0] TYPE_GOP      = 8'hB8;
    localparam logic [7:0] TYPE_PICTURE  = 8'h00;
    localparam logic [7:0] TYPE_VOP      = 8'hB6;
    localparam logic [2:0] PIC_TYPE_I    = 3'h1;
    localparam logic [1:0] VOP_TYPE_I    = 2'h0;
    localparam logic [1:0] ZERO_RUN_MAX  = 2'd2;

    typedef enum logic {
        KIND_MPEG2 = 1'b0,
        KIND_MPEG4 = 1'b1
    } t_stream_kind;

    typedef enum logic [1:0] {
        PHASE_SEARCH = 2'd0,
        PHASE_TYPE   = 2'd1,
        PHASE_SKIP   = 2'd2,
        PHASE_CODING = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CAUSE_GOP      = 2'd0,
        CAUSE_INTRA    = 2'd1,
        CAUSE_NONINTRA = 2'd2,
        CAUSE_NONE     = 2'd3
    } t_cause;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       unit_end;
    } t_item;

    typedef struct packed {
        logic       hit;
        logic       is_keyframe;
        t_cause     cause;
    } t_result;

endpackage

// ===== hdl/mvkd_if.sv =====
// Valid/ready channel interfaces for the MPEG video keyframe detector.
// One carries stream bytes in, the other carries one decision per unit out.
// No dependencies.
interface mvkd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       unit_end;

    modport source (output valid, output data_byte, output unit_end, input ready);
    modport sink   (input valid, input data_byte, input unit_end, output ready);
endinterface

interface mvkd_out_if;
    logic       valid;
    logic       ready;
    logic       is_keyframe;
    logic [1:0] decision_cause;

    modport source (output valid, output is_keyframe, output decision_cause, input ready);
    modport sink   (input valid, input is_keyframe, input decision_cause, output ready);
endinterface

// ===== hdl/mvkd_scan.sv =====
// Start code scanner and header decoder of the MPEG video keyframe detector.
// Keeps the per-unit scan state and decides one item per cycle while i_en is high.
// Depends on mvkd_pkg.
module mvkd_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_kind,
    input  mvkd_pkg::t_item i_item,
    output mvkd_pkg::t_result o_result
);
    import mvkd_pkg::*;

    t_phase     r_phase, n_phase;
    logic [1:0] r_zero_run, n_zero_run;
    logic       r_decided, n_decided;
    logic       w_decide;
    t_cause     w_cause;

    always_comb begin
        n_phase    = r_phase;
        n_zero_run = r_zero_run;
        n_decided  = r_decided;
        if (!r_decided) begin
            unique case (r_phase)
                PHASE_TYPE: begin
                    n_zero_run = 2'd0;
                    n_phase    = PHASE_SEARCH;
                    if (i_kind == KIND_MPEG2) begin
                        if (i_item.data_byte == TYPE_GOP) begin
                            n_decided = 1'b1;
                        end else if (i_item.data_byte == TYPE_PICTURE) begin
                            n_phase = PHASE_SKIP;
                        end
                    end else if (i_item.data_byte == TYPE_VOP) begin
                        n_phase = PHASE_CODING;
                    end
                end
                PHASE_SKIP: begin
                    n_zero_run = 2'd0;
                    n_phase    = PHASE_CODING;
                end
                PHASE_CODING: begin
                    n_zero_run = 2'd0;
                    n_phase    = PHASE_SEARCH;
                    n_decided  = 1'b1;
                end
                PHASE_SEARCH: begin
                    if (i_item.data_byte == BYTE_ONE && r_zero_run == ZERO_RUN_MAX) begin
                        n_zero_run = 2'd0;
                        n_phase    = PHASE_TYPE;
                    end else if (i_item.data_byte == BYTE_ZERO) begin
                        if (r_zero_run != ZERO_RUN_MAX) begin
                            n_zero_run = r_zero_run + 2'd1;
                        end
                    end else begin
                        n_zero_run = 2'd0;
                    end
                end
                default: begin
                    n_phase = PHASE_SEARCH;
                end
            endcase
        end
        if (i_item.unit_end) begin
            n_phase    = PHASE_SEARCH;
            n_zero_run = 2'd0;
            n_decided  = 1'b0;
        end
    end

    always_comb begin
        w_decide = 1'b0;
        w_cause  = CAUSE_NONE;
        if (!r_decided) begin
            unique case (r_phase)
                PHASE_TYPE: begin
                    if (i_kind == KIND_MPEG2 && i_item.data_byte == TYPE_GOP) begin
                        w_decide = 1'b1;
                        w_cause  = CAUSE_GOP;
                    end
                end
                PHASE_CODING: begin
                    w_decide = 1'b1;
                    if (i_kind == KIND_MPEG2) begin
                        w_cause = (i_item.data_byte[5:3] == PIC_TYPE_I) ? CAUSE_INTRA
                                                                        : CAUSE_NONINTRA;
                    end else begin
                        w_cause = (i_item.data_byte[7:6] == VOP_TYPE_I) ? CAUSE_INTRA
                                                                        : CAUSE_NONINTRA;
                    end
                end
                PHASE_SEARCH, PHASE_SKIP: begin
                    w_decide = 1'b0;
                end
                default: begin
                    w_decide = 1'b0;
                end
            endcase
        end
        o_result.hit         = w_decide || (!r_decided && i_item.unit_end);
        o_result.cause       = w_cause;
        o_result.is_keyframe = (w_cause == CAUSE_GOP) || (w_cause == CAUSE_INTRA);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PHASE_SEARCH;
            r_zero_run <= 2'd0;
            r_decided  <= 1'b0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_zero_run <= n_zero_run;
            r_decided  <= n_decided;
        end
    end

endmodule

// ===== hdl/mpeg_video_keyframe_detector.sv =====
// Top level of the MPEG video keyframe detector.
// The deciding or last byte is held in the input register and its result in the result register.
// Throughput: one byte item per cycle unless a pending result is stalled by the downstream ready.
// The handshake ready depends on the downstream ready through both stages.
// Reset clears both stage valids and the scan state, and sets the stream kind to MPEG-1/2.
// Depends on mvkd_pkg, mvkd_in_if, mvkd_out_if and mvkd_scan.
module mpeg_video_keyframe_detector (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    mvkd_in_if.sink          i_byte,
    mvkd_out_if.source       o_result
);
    import mvkd_pkg::*;

    logic    r_kind;
    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    logic    r_out_key;
    t_cause  r_out_cause;
    logic    w_advance;
    t_item   w_item;
    t_result w_result;

    assign w_item.data_byte = i_byte.data_byte;
    assign w_item.unit_end  = i_byte.unit_end;

    assign w_advance    = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_byte.ready = !r_in_valid || w_advance;

    mvkd_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_advance),
        .i_kind   (r_kind),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_MPEG2;
        end else if (i_cfg_wr_en) begin
            r_kind <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_item <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_result.hit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_result.hit) begin
            r_out_key   <= w_result.is_keyframe;
            r_out_cause <= w_result.cause;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.is_keyframe    = r_out_key;
    assign o_result.decision_cause = r_out_cause;

endmodule
